// ----- sv/isig_pkg.sv -----
// ----------------------------------------------------------------------------
// isig_pkg
// shared types, register codes and fixed-point constants of the int8 sigmoid
// ----------------------------------------------------------------------------
package isig_pkg;

  typedef struct packed {
    logic signed [7:0] sample;
    logic              last_in;
  } isig_in_t;

  typedef struct packed {
    logic signed [7:0] result;
    logic              last_out;
  } isig_out_t;

  // sideband that rides along every pipeline stage
  typedef struct packed {
    logic valid;
    logic last;
    logic neg;
  } isig_ctl_t;

  typedef enum logic [1:0] {
    REG_DQ_SCALE      = 2'd0,
    REG_INV_SCALE_OUT = 2'd1,
    REG_ACT_MIN       = 2'd2,
    REG_ACT_MAX       = 2'd3
  } isig_reg_t;

  localparam int          CFG_AW       = 4;
  localparam logic [37:0] LN2_Q32      = 38'd2977044472;
  // 34 * ln2 in q32, exp(-a) is zero from here on
  localparam logic [37:0] EXP_LIMIT    = 38'd101219512048;
  localparam int          K_W          = 6;
  localparam int          SRCH_STAGES  = 3;
  localparam int          SERIES_TERMS = 16;
  localparam int          DIV_Q_W      = 31;
  localparam int          DIV_STAGES   = 16;
  localparam logic [30:0] SIG_ONE      = 31'h4000_0000;

  // ceil(2^36 / n), exact quotient of a 32-bit value by n after >> 36
  function automatic logic [36:0] recip_magic(input int n);
    logic [36:0] m;
    unique case (n)
      1:       m = 37'd68719476736;
      2:       m = 37'd34359738368;
      3:       m = 37'd22906492246;
      4:       m = 37'd17179869184;
      5:       m = 37'd13743895348;
      6:       m = 37'd11453246123;
      7:       m = 37'd9817068106;
      8:       m = 37'd8589934592;
      9:       m = 37'd7635497416;
      10:      m = 37'd6871947674;
      11:      m = 37'd6247225158;
      12:      m = 37'd5726623062;
      13:      m = 37'd5286113596;
      14:      m = 37'd4908534053;
      15:      m = 37'd4581298450;
      16:      m = 37'd4294967296;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- sv/isig_reduce.sv -----
// ----------------------------------------------------------------------------
// isig_reduce
// magnitude times input scale, then a = k*ln2 + r by restoring search
// ----------------------------------------------------------------------------
module isig_reduce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  isig_pkg::isig_ctl_t ctl_i,
  input  logic [7:0]          sample_i,
  input  logic [23:0]         dq_scale_i,
  output isig_pkg::isig_ctl_t ctl_o,
  output logic [31:0]         r_o,
  output logic [5:0]          k_o,
  output logic                zero_o
);
  import isig_pkg::*;

  logic [7:0]  mag;
  logic [43:0] a32;
  logic        big;
  logic [31:0] a_r;
  isig_ctl_t   ctl0_r;
  isig_ctl_t   ctl_r  [SRCH_STAGES+1];
  logic [37:0] rem_r  [SRCH_STAGES+1];
  logic [5:0]  k_r    [SRCH_STAGES+1];
  logic        zero_r [SRCH_STAGES+1];
  logic [37:0] rem_nxt [SRCH_STAGES];
  logic [5:0]  k_nxt   [SRCH_STAGES];

  assign mag = sample_i[7] ? 8'(~sample_i + 8'd1) : sample_i;
  assign a32 = {a_r, 12'd0};
  assign big = a32 >= 44'(EXP_LIMIT);

  // two quotient bits per stage, msb first
  always_comb begin
    logic [37:0] rem_t;
    logic [5:0]  k_t;
    logic [37:0] thr;
    for (int s = 0; s < SRCH_STAGES; s++) begin
      rem_t = rem_r[s];
      k_t   = k_r[s];
      for (int j = 0; j < 2; j++) begin
        thr = LN2_Q32 << (5 - 2 * s - j);
        if (rem_t >= thr) begin
          rem_t = rem_t - thr;
          k_t   = {k_t[4:0], 1'b1};
        end else begin
          k_t   = {k_t[4:0], 1'b0};
        end
      end
      rem_nxt[s] = rem_t;
      k_nxt[s]   = k_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
      for (int i = 0; i <= SRCH_STAGES; i++) ctl_r[i] <= '0;
    end else if (en) begin
      ctl0_r   <= ctl_i;
      ctl_r[0] <= ctl0_r;
      for (int i = 0; i < SRCH_STAGES; i++) ctl_r[i+1] <= ctl_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r       <= 32'(mag) * 32'(dq_scale_i);
      rem_r[0]  <= a32[37:0];
      k_r[0]    <= '0;
      zero_r[0] <= big;
      for (int i = 0; i < SRCH_STAGES; i++) begin
        rem_r[i+1]  <= rem_nxt[i];
        k_r[i+1]    <= k_nxt[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign ctl_o  = ctl_r[SRCH_STAGES];
  assign r_o    = rem_r[SRCH_STAGES][31:0];
  assign k_o    = k_r[SRCH_STAGES];
  assign zero_o = zero_r[SRCH_STAGES];

endmodule

// ----- sv/isig_series.sv -----
// ----------------------------------------------------------------------------
// isig_series
// exp(-r) by a taylor series up to r^16, two stages per term from r^2 on, then >> k
// ----------------------------------------------------------------------------
module isig_series (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  isig_pkg::isig_ctl_t ctl_i,
  input  logic [31:0]         r_i,
  input  logic [5:0]          k_i,
  input  logic                zero_i,
  output isig_pkg::isig_ctl_t ctl_o,
  output logic [32:0]         e_o
);
  import isig_pkg::*;

  localparam int NT = SERIES_TERMS;
  localparam logic signed [34:0] ONE_Q32 = 35'sd4294967296;

  isig_ctl_t          ctla_r [2:NT];
  isig_ctl_t          ctlb_r [1:NT];
  isig_ctl_t          ctle_r;
  logic [31:0]        ra_r   [2:NT];
  logic [31:0]        rb_r   [1:NT];
  logic [31:0]        pa_r   [2:NT];
  logic [31:0]        term_r [1:NT];
  logic [5:0]         ka_r   [2:NT];
  logic [5:0]         kb_r   [1:NT];
  logic               za_r   [2:NT];
  logic               zb_r   [1:NT];
  logic signed [34:0] acca_r [2:NT];
  logic signed [34:0] acc_r  [1:NT];
  logic [31:0]        p_nxt   [2:NT];
  logic [31:0]        t_nxt   [2:NT];
  logic signed [34:0] acc_nxt [2:NT];
  logic [32:0]        acc_sat;
  logic [32:0]        e_nxt;
  logic [32:0]        e_r;

  always_comb begin
    logic [63:0] prod;
    logic [68:0] pm;
    for (int n = 2; n <= NT; n++) begin
      prod     = 64'(term_r[n-1]) * 64'(rb_r[n-1]);
      p_nxt[n] = prod[63:32];
      pm       = 69'(pa_r[n]) * 69'(recip_magic(n));
      t_nxt[n] = pm[67:36];
      if ((n & 1) != 0) acc_nxt[n] = acca_r[n] - $signed({3'b000, t_nxt[n]});
      else              acc_nxt[n] = acca_r[n] + $signed({3'b000, t_nxt[n]});
    end
  end

  // clamp the sum to [0, 1.0] then scale by 2^-k, or give zero past the limit
  always_comb begin
    if (acc_r[NT] < 0)            acc_sat = '0;
    else if (acc_r[NT] > ONE_Q32) acc_sat = 33'h1_0000_0000;
    else                          acc_sat = acc_r[NT][32:0];
    e_nxt = zb_r[NT] ? '0 : (acc_sat >> kb_r[NT]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctle_r <= '0;
      for (int n = 1; n <= NT; n++) ctlb_r[n] <= '0;
      for (int n = 2; n <= NT; n++) ctla_r[n] <= '0;
    end else if (en) begin
      ctlb_r[1] <= ctl_i;
      for (int n = 2; n <= NT; n++) begin
        ctla_r[n] <= ctlb_r[n-1];
        ctlb_r[n] <= ctla_r[n];
      end
      ctle_r <= ctlb_r[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r[1] <= r_i;
      acc_r[1]  <= ONE_Q32 - $signed({3'b000, r_i});
      rb_r[1]   <= r_i;
      kb_r[1]   <= k_i;
      zb_r[1]   <= zero_i;
      for (int n = 2; n <= NT; n++) begin
        pa_r[n]   <= p_nxt[n];
        acca_r[n] <= acc_r[n-1];
        ra_r[n]   <= rb_r[n-1];
        ka_r[n]   <= kb_r[n-1];
        za_r[n]   <= zb_r[n-1];
        term_r[n] <= t_nxt[n];
        acc_r[n]  <= acc_nxt[n];
        rb_r[n]   <= ra_r[n];
        kb_r[n]   <= ka_r[n];
        zb_r[n]   <= za_r[n];
      end
      e_r <= e_nxt;
    end
  end

  assign ctl_o = ctle_r;
  assign e_o   = e_r;

endmodule

// ----- sv/isig_div.sv -----
// ----------------------------------------------------------------------------
// isig_div
// pipelined long division (2^62 + d/2) / d, d = 2^32 + e, two bits a stage (one in the last)
// ----------------------------------------------------------------------------
module isig_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  isig_pkg::isig_ctl_t ctl_i,
  input  logic [32:0]         e_i,
  output isig_pkg::isig_ctl_t ctl_o,
  output logic [30:0]         q_o
);
  import isig_pkg::*;

  logic [33:0] d_c;
  logic [62:0] num_c;
  isig_ctl_t   ctl_r [DIV_STAGES+1];
  logic [33:0] d_r   [DIV_STAGES+1];
  logic [33:0] rem_r [DIV_STAGES+1];
  logic [30:0] nb_r  [DIV_STAGES+1];
  logic [30:0] q_r   [DIV_STAGES+1];
  logic [33:0] rem_nxt [DIV_STAGES];
  logic [30:0] nb_nxt  [DIV_STAGES];
  logic [30:0] q_nxt   [DIV_STAGES];

  assign d_c   = 34'h1_0000_0000 + 34'(e_i);
  assign num_c = (63'd1 << 62) + 63'(d_c >> 1);

  always_comb begin
    logic [33:0] rem_t;
    logic [30:0] nb_t;
    logic [30:0] q_t;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_t = rem_r[s];
      nb_t  = nb_r[s];
      q_t   = q_r[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < DIV_Q_W) begin
          rem_t = {rem_t[32:0], nb_t[30]};
          nb_t  = {nb_t[29:0], 1'b0};
          if (rem_t >= d_r[s]) begin
            rem_t = rem_t - d_r[s];
            q_t   = {q_t[29:0], 1'b1};
          end else begin
            q_t   = {q_t[29:0], 1'b0};
          end
        end
      end
      rem_nxt[s] = rem_t;
      nb_nxt[s]  = nb_t;
      q_nxt[s]   = q_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STAGES; i++) ctl_r[i] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      for (int i = 0; i < DIV_STAGES; i++) ctl_r[i+1] <= ctl_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]   <= d_c;
      rem_r[0] <= 34'(num_c[62:31]);
      nb_r[0]  <= num_c[30:0];
      q_r[0]   <= '0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        d_r[i+1]   <= d_r[i];
        rem_r[i+1] <= rem_nxt[i];
        nb_r[i+1]  <= nb_nxt[i];
        q_r[i+1]   <= q_nxt[i];
      end
    end
  end

  assign ctl_o = ctl_r[DIV_STAGES];
  assign q_o   = q_r[DIV_STAGES];

endmodule

// ----- sv/int8_quantized_sigmoid.sv -----
// ----------------------------------------------------------------------------
// int8_quantized_sigmoid
// int8 sigmoid: clamp(round(sigmoid(sample*dq_scale)*inv_scale_out)) per word
// ----------------------------------------------------------------------------
// pipeline: 57 stages plus the output register between input accept and
//   out_valid, mostly set by 15 taylor terms at two stages each and the
//   31-bit long division at two quotient bits per stage
// throughput: one word per cycle, sustained while out_ready stays high
// reset: synchronous active-low rst_n clears all valid bits and loads the
//   register defaults; the block takes words on the first cycle after reset
module int8_quantized_sigmoid (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  isig_pkg::isig_in_t          in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output isig_pkg::isig_out_t         out_word,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [isig_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import isig_pkg::*;

  // configuration registers
  logic [23:0]       dq_scale_r;
  logic [23:0]       inv_scale_out_r;
  logic signed [7:0] act_min_r;
  logic signed [7:0] act_max_r;
  logic              cfg_wr;
  isig_reg_t         cfg_idx;

  // whole pipeline advances together; only a full skid slot freezes it
  logic      pipe_en;
  isig_ctl_t in_ctl;

  isig_ctl_t   red_ctl;
  logic [31:0] red_r;
  logic [5:0]  red_k;
  logic        red_zero;
  isig_ctl_t   ser_ctl;
  logic [32:0] ser_e;
  isig_ctl_t   div_ctl;
  logic [30:0] div_q;

  // output side stages
  isig_ctl_t          ctl1_r, ctl2_r, ctl3_r;
  logic [30:0]        sig_nxt;
  logic [30:0]        sig1_r;
  logic [54:0]        prod2_r;
  logic [55:0]        rnd_sum;
  logic signed [14:0] v_s;
  logic signed [7:0]  res_nxt;
  logic signed [7:0]  res3_r;

  // output register and skid slot
  logic      out_v_r, out_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  isig_out_t out_r, skid_r;
  logic      out_take;
  logic      load_out, load_skid, out_from_skid;

  // ---------------------------------------------------------------- config
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = isig_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dq_scale_r      <= 24'd65536;
      inv_scale_out_r <= 24'd1048576;
      act_min_r       <= -8'sd128;
      act_max_r       <= 8'sd127;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DQ_SCALE:      dq_scale_r      <= cfg_pwdata[23:0];
        REG_INV_SCALE_OUT: inv_scale_out_r <= cfg_pwdata[23:0];
        REG_ACT_MIN:       act_min_r       <= cfg_pwdata[7:0];
        REG_ACT_MAX:       act_max_r       <= cfg_pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DQ_SCALE:      cfg_prdata = {8'd0, dq_scale_r};
      REG_INV_SCALE_OUT: cfg_prdata = {8'd0, inv_scale_out_r};
      REG_ACT_MIN:       cfg_prdata = {24'd0, act_min_r};
      REG_ACT_MAX:       cfg_prdata = {24'd0, act_max_r};
    endcase
  end

  // ---------------------------------------------------------------- datapath
  // no word is taken while reset is held
  assign pipe_en  = !skid_v_r;
  assign in_ready = pipe_en && rst_n;
  assign in_ctl   = '{valid: in_valid, last: in_word.last_in, neg: in_word.sample[7]};

  // |sample| * dq_scale and range reduction, 5 stages
  isig_reduce u_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .ctl_i      (in_ctl),
    .sample_i   (in_word.sample),
    .dq_scale_i (dq_scale_r),
    .ctl_o      (red_ctl),
    .r_o        (red_r),
    .k_o        (red_k),
    .zero_o     (red_zero)
  );

  // exp(-|x|) in q32, 32 stages
  isig_series u_series (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .ctl_i  (red_ctl),
    .r_i    (red_r),
    .k_i    (red_k),
    .zero_i (red_zero),
    .ctl_o  (ser_ctl),
    .e_o    (ser_e)
  );

  // sigmoid(|x|) in q30 by rounded division, 17 stages
  isig_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .ctl_i (ser_ctl),
    .e_i   (ser_e),
    .ctl_o (div_ctl),
    .q_o   (div_q)
  );

  // saturate at 1.0 and mirror for negative samples
  always_comb begin
    sig_nxt = (div_q > SIG_ONE) ? SIG_ONE : div_q;
    if (div_ctl.neg) sig_nxt = SIG_ONE - sig_nxt;
  end

  // round half up (product is never negative) and clamp, min first then max
  assign rnd_sum = {1'b0, prod2_r} + (56'd1 << 41);
  assign v_s     = $signed({1'b0, rnd_sum[55:42]});

  always_comb begin
    logic signed [14:0] v_t;
    v_t = v_s;
    if (v_t < 15'(act_min_r)) v_t = 15'(act_min_r);
    if (v_t > 15'(act_max_r)) v_t = 15'(act_max_r);
    res_nxt = v_t[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (pipe_en) begin
      ctl1_r <= div_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sig1_r  <= sig_nxt;
      prod2_r <= 55'(sig1_r) * 55'(inv_scale_out_r);
      res3_r  <= res_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  // the tail word goes to the output register when it is free, else to the
  // skid slot; a full skid slot stalls the pipeline the next cycle
  assign out_take = out_v_r && out_ready;

  always_comb begin
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (out_take) out_v_nxt = 1'b0;
    if (skid_v_r) begin
      if (out_take) begin
        out_from_skid = 1'b1;
        out_v_nxt     = 1'b1;
        skid_v_nxt    = 1'b0;
      end
    end else if (ctl3_r.valid) begin
      if (!out_v_r || out_take) begin
        load_out  = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_from_skid)  out_r <= skid_r;
    else if (load_out)  out_r <= '{result: res3_r, last_out: ctl3_r.last};
    if (load_skid)      skid_r <= '{result: res3_r, last_out: ctl3_r.last};
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  // ---------------------------------------------------------------- checks
  // a parked skid word always has a word ahead of it in the output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot full with empty output register");

  // the skid word is only released when the output word is taken
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ready) |=> (skid_v_r && $stable(skid_r)))
    else $error("skid word lost while output stalled");

  // with ordered bounds the delivered value lies inside them
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (act_min_r <= act_max_r)) |->
      ((out_r.result >= act_min_r) && (out_r.result <= act_max_r)))
    else $error("result outside clamp bounds");

endmodule
